// ===== sv/deadline_ordered_timer_table_defines.svh =====
// assertion macros for the deadline ordered timer table
`ifndef DEADLINE_ORDERED_TIMER_TABLE_DEFINES_SVH
`define DEADLINE_ORDERED_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define DOTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DOTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dott_pkg.sv =====
// shared constants for the deadline ordered timer table
package dott_pkg;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned HDL_W  = 4;
    localparam int unsigned WORD_W = 32;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [HDL_W-1:0]  t_hdl;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_cmd CMD_TICK   = 2'd0;
    localparam t_cmd CMD_CREATE = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;
    localparam t_cmd CMD_RSVD   = 2'd3;

    localparam t_kind K_CREATED  = 3'd0;
    localparam t_kind K_ZERO     = 3'd1;
    localparam t_kind K_FULL     = 3'd2;
    localparam t_kind K_DELETED  = 3'd3;
    localparam t_kind K_NOTFOUND = 3'd4;
    localparam t_kind K_EXPIRED  = 3'd5;
    localparam t_kind K_DONE     = 3'd6;
endpackage

// ===== sv/dott_if.sv =====
// request and result channel interfaces
interface dott_in_if;
    import dott_pkg::*;
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_word delay;
    t_hdl  handle;
    t_word user_tag;
    modport source (output valid, command, delay, handle, user_tag, input ready);
    modport sink   (input valid, command, delay, handle, user_tag, output ready);
endinterface

interface dott_out_if;
    import dott_pkg::*;
    logic  valid;
    logic  ready;
    t_kind kind;
    t_hdl  slot;
    t_word tag_out;
    t_word deadline_out;
    t_word tick_now;
    logic  last;
    modport source (output valid, kind, slot, tag_out, deadline_out, tick_now, last,
                    input ready);
    modport sink   (input valid, kind, slot, tag_out, deadline_out, tick_now, last,
                    output ready);
endinterface

// ===== sv/dott_ram.sv =====
// single write port, single registered read port memory
module dott_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/deadline_ordered_timer_table.sv =====
// top level of the deadline ordered timer table
// usage:
//  requests enter on i_in (valid/ready); command tick, create or delete.
//  results leave on o_out (valid/ready); the final result of a request has last set.
//  one request at a time: i_in.ready is high only while the sequencer is idle.
//  create: a zero delay goes straight to the result, else a scan for a free
//  slot, a walk past earlier ordered entries, a move per later entry, then insert.
//  delete: a search of the ordered entries, a move per later entry, then free.
//  tick: a walk of the ordered entries plus the done result.
//  the order list, deadline and tag memories each have one port pair with a
//  registered read.
//  each result passes through the output register; if the receiver stalls
//  the sequencer waits with the next result and the register holds.
//  reset (synchronous, active low) clears tick count, entry count and the
//  used and armed bits; memories need no clearing, entries are written first.
module deadline_ordered_timer_table #(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    dott_in_if.sink     i_in,
    dott_out_if.source  o_out
);
    import dott_pkg::*;

    localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_EMIT    = 5'd1;
    localparam logic [4:0] S_T_ORD   = 5'd2;
    localparam logic [4:0] S_T_SLOT  = 5'd3;
    localparam logic [4:0] S_T_CMP   = 5'd4;
    localparam logic [4:0] S_C_SCAN  = 5'd5;
    localparam logic [4:0] S_C_ORD   = 5'd6;
    localparam logic [4:0] S_C_SLOT  = 5'd7;
    localparam logic [4:0] S_C_CMP   = 5'd8;
    localparam logic [4:0] S_C_SHIFT = 5'd9;
    localparam logic [4:0] S_C_MOVE  = 5'd10;
    localparam logic [4:0] S_C_INS   = 5'd11;
    localparam logic [4:0] S_D_ORD   = 5'd12;
    localparam logic [4:0] S_D_CHK   = 5'd13;
    localparam logic [4:0] S_D_SHIFT = 5'd14;
    localparam logic [4:0] S_D_MOVE  = 5'd15;
    localparam logic [4:0] S_D_FIN   = 5'd16;

    logic [4:0]             r_state, n_state, r_ret, n_ret;
    logic [CW-1:0]          r_i, n_i, r_j, n_j, r_count, n_count;
    logic [SW-1:0]          r_s, n_s;
    t_word                  r_tick, n_tick, r_dl, n_dl, r_tag, n_tag;
    logic [TIMER_SLOTS-1:0] r_used, n_used, r_armed, n_armed;
    t_kind                  r_p_kind, n_p_kind;
    t_hdl                   r_p_slot, n_p_slot;
    t_word                  r_p_tag, n_p_tag, r_p_dl, n_p_dl;
    logic                   r_p_last, n_p_last;

    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    t_hdl                   r_out_slot, n_out_slot;
    t_word                  r_out_tag, n_out_tag, r_out_dl, n_out_dl;
    t_word                  r_out_tick, n_out_tick;
    logic                   r_out_last, n_out_last;

    logic                   ord_re, ord_we, sl_re, sl_we;
    logic [SW-1:0]          ord_raddr, ord_waddr, ord_wdata, ord_rdata, sl_raddr;
    t_word                  dl_rdata, tag_rdata;
    logic                   in_take, out_free;

    dott_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(SW)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_re(ord_re), .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );
    dott_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(WORD_W)) u_deadline (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(r_s), .i_wdata(r_dl),
        .i_re(sl_re), .i_raddr(sl_raddr), .o_rdata(dl_rdata)
    );
    dott_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(WORD_W)) u_tag (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(r_s), .i_wdata(r_tag),
        .i_re(sl_re), .i_raddr(sl_raddr), .o_rdata(tag_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_i = r_i; n_j = r_j; n_s = r_s; n_count = r_count;
        n_tick = r_tick; n_dl = r_dl; n_tag = r_tag;
        n_used = r_used; n_armed = r_armed;
        n_p_kind = r_p_kind; n_p_slot = r_p_slot; n_p_tag = r_p_tag;
        n_p_dl = r_p_dl; n_p_last = r_p_last;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_kind = r_out_kind; n_out_slot = r_out_slot; n_out_tag = r_out_tag;
        n_out_dl = r_out_dl; n_out_tick = r_out_tick; n_out_last = r_out_last;
        ord_re = 1'b0; ord_raddr = r_i[SW-1:0];
        ord_we = 1'b0; ord_waddr = r_j[SW-1:0]; ord_wdata = ord_rdata;
        sl_re = 1'b0; sl_raddr = ord_rdata; sl_we = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_i = '0;
                    n_p_slot = '0; n_p_tag = '0; n_p_dl = '0; n_p_last = 1'b1;
                    n_ret = S_IDLE;
                    if (i_in.command == CMD_TICK) begin
                        n_tick = r_tick + 1'b1;
                        n_state = S_T_ORD;
                    end else if (i_in.command == CMD_CREATE) begin
                        n_dl = r_tick + i_in.delay;
                        n_tag = i_in.user_tag;
                        if (i_in.delay == '0) begin
                            n_p_kind = K_ZERO;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_C_SCAN;
                        end
                    end else if (i_in.command == CMD_DELETE) begin
                        n_s = SW'(i_in.handle);
                        if (32'(i_in.handle) < 32'(TIMER_SLOTS)
                                && r_used[SW'(i_in.handle)]) begin
                            n_state = S_D_ORD;
                        end else begin
                            n_p_kind = K_NOTFOUND;
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind = r_p_kind; n_out_slot = r_p_slot; n_out_tag = r_p_tag;
                    n_out_dl = r_p_dl; n_out_tick = r_tick; n_out_last = r_p_last;
                    n_state = r_ret;
                end
            end
            S_T_ORD: begin
                if (r_i < r_count) begin
                    ord_re = 1'b1;
                    n_state = S_T_SLOT;
                end else begin
                    n_p_kind = K_DONE; n_p_slot = '0; n_p_tag = '0; n_p_dl = '0;
                    n_p_last = 1'b1; n_ret = S_IDLE;
                    n_state = S_EMIT;
                end
            end
            S_T_SLOT: begin
                sl_re = 1'b1;
                n_s = ord_rdata;
                n_state = S_T_CMP;
            end
            S_T_CMP: begin
                if (dl_rdata > r_tick) begin
                    n_p_kind = K_DONE; n_p_slot = '0; n_p_tag = '0; n_p_dl = '0;
                    n_p_last = 1'b1; n_ret = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_i = r_i + 1'b1;
                    if (r_armed[r_s]) begin
                        n_armed[r_s] = 1'b0;
                        n_p_kind = K_EXPIRED; n_p_slot = HDL_W'(r_s);
                        n_p_tag = tag_rdata; n_p_dl = dl_rdata; n_p_last = 1'b0;
                        n_ret = S_T_ORD;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_T_ORD;
                    end
                end
            end
            S_C_SCAN: begin
                if (!r_used[r_i[SW-1:0]]) begin
                    n_s = r_i[SW-1:0];
                    n_i = '0;
                    n_state = S_C_ORD;
                end else if (r_i == CW'(TIMER_SLOTS - 1)) begin
                    n_p_kind = K_FULL;
                    n_state = S_EMIT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_C_ORD: begin
                if (r_i < r_count) begin
                    ord_re = 1'b1;
                    n_state = S_C_SLOT;
                end else begin
                    n_j = r_count;
                    n_state = S_C_SHIFT;
                end
            end
            S_C_SLOT: begin
                sl_re = 1'b1;
                n_state = S_C_CMP;
            end
            S_C_CMP: begin
                if (dl_rdata >= r_dl) begin
                    n_j = r_count;
                    n_state = S_C_SHIFT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_C_ORD;
                end
            end
            S_C_SHIFT: begin
                if (r_j > r_i) begin
                    ord_re = 1'b1;
                    ord_raddr = SW'(r_j - 1'b1);
                    n_state = S_C_MOVE;
                end else begin
                    n_state = S_C_INS;
                end
            end
            S_C_MOVE: begin
                ord_we = 1'b1;
                n_j = r_j - 1'b1;
                n_state = S_C_SHIFT;
            end
            S_C_INS: begin
                ord_we = 1'b1;
                ord_waddr = r_i[SW-1:0];
                ord_wdata = r_s;
                sl_we = 1'b1;
                n_used[r_s] = 1'b1;
                n_armed[r_s] = 1'b1;
                n_count = r_count + 1'b1;
                n_p_kind = K_CREATED; n_p_slot = HDL_W'(r_s); n_p_dl = r_dl;
                n_state = S_EMIT;
            end
            S_D_ORD: begin
                if (r_i < r_count) begin
                    ord_re = 1'b1;
                    n_state = S_D_CHK;
                end else begin
                    n_state = S_D_FIN;
                end
            end
            S_D_CHK: begin
                if (ord_rdata == r_s) begin
                    n_j = r_i;
                    n_state = S_D_SHIFT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_D_ORD;
                end
            end
            S_D_SHIFT: begin
                if (r_j + 1'b1 < r_count) begin
                    ord_re = 1'b1;
                    ord_raddr = SW'(r_j + 1'b1);
                    n_state = S_D_MOVE;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_D_FIN;
                end
            end
            S_D_MOVE: begin
                ord_we = 1'b1;
                n_j = r_j + 1'b1;
                n_state = S_D_SHIFT;
            end
            S_D_FIN: begin
                n_used[r_s] = 1'b0;
                n_armed[r_s] = 1'b0;
                n_p_kind = K_DELETED; n_p_slot = HDL_W'(r_s);
                n_state = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_count <= '0;
            r_tick <= '0;
            r_used <= '0;
            r_armed <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_count <= n_count;
            r_tick <= n_tick;
            r_used <= n_used;
            r_armed <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_s <= n_s; r_dl <= n_dl; r_tag <= n_tag;
        r_p_kind <= n_p_kind; r_p_slot <= n_p_slot; r_p_tag <= n_p_tag;
        r_p_dl <= n_p_dl; r_p_last <= n_p_last;
        r_out_kind <= n_out_kind; r_out_slot <= n_out_slot; r_out_tag <= n_out_tag;
        r_out_dl <= n_out_dl; r_out_tick <= n_out_tick; r_out_last <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_kind;
    assign o_out.slot         = r_out_slot;
    assign o_out.tag_out      = r_out_tag;
    assign o_out.deadline_out = r_out_dl;
    assign o_out.tick_now     = r_out_tick;
    assign o_out.last         = r_out_last;

`include "deadline_ordered_timer_table_defines.svh"

    `DOTT_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(TIMER_SLOTS), "entry count overflow")
    `DOTT_ASSERT_NEXT(a_tick_step, in_take && i_in.command == CMD_TICK, r_tick == $past(r_tick) + 1'b1, "tick not advanced")
    `DOTT_ASSERT_NEXT(a_insert_count, r_state == S_C_INS, r_count == $past(r_count) + 1'b1 && r_used[$past(r_s)], "insert not recorded")
endmodule
